FILE: rtl/core/ahic_pkg.sv
// ----------------------------------------------------------------------------
// ahic_pkg
// Shared types and constants of the aligned Hamming / indel counter.
// ----------------------------------------------------------------------------
`default_nettype none

package ahic_pkg;

   // Default sequence length limit
   localparam int unsigned MAX_LEN_DEFAULT = 1024;

   // Result count width and saturation value
   localparam int unsigned OUT_W   = 11;
   localparam int unsigned OUT_MAX = 2047;

   // Byte width of one sequence symbol
   localparam int unsigned CHAR_W = 8;

   // Gap code after reset (ASCII dash)
   localparam logic [CHAR_W-1:0] GAP_RESET = 8'd45;

   // Entries in the front-to-back queue, a power of two
   localparam int unsigned QUEUE_DEPTH = 2;

   // One classified position pair
   typedef struct packed {
      logic diff;
      logic a_gap;
      logic b_gap;
      logic last;
   } ahic_item_type;

   // Queue status seen by the front
   typedef struct packed {
      logic full;
   } ahic_qstat_type;

endpackage

`default_nettype wire

FILE: rtl/core/ahic_front.sv
// ----------------------------------------------------------------------------
// ahic_front
// Holds the gap code, accepts position pairs and classifies each one.
// ----------------------------------------------------------------------------
`default_nettype none

module ahic_front import ahic_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [CHAR_W-1:0] req_char_a,
   input  wire logic [CHAR_W-1:0] req_char_b,
   input  wire logic              req_last_position,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CHAR_W-1:0] csr_data,
   input  wire ahic_qstat_type    q_stat,
   output logic                   push_valid,
   output ahic_item_type          push_item
);

   logic [CHAR_W-1:0] gap_ff;
   logic [CHAR_W-1:0] gap_in;

   // Take a gap code write on every transfer
   assign csr_ready = 1'b1;

   always_comb begin
      gap_in = gap_ff;
      if (csr_valid && csr_ready) begin
         gap_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= GAP_RESET;
      end else begin
         gap_ff <= gap_in;
      end
   end

   // Stall while the queue has no free slot
   assign req_stall  = q_stat.full;
   assign push_valid = req_valid;

   // Classify the pair against the current gap code
   always_comb begin
      push_item.diff  = (req_char_a != req_char_b);
      push_item.a_gap = (req_char_a == gap_ff);
      push_item.b_gap = (req_char_b == gap_ff);
      push_item.last  = req_last_position;
   end

endmodule

`default_nettype wire

FILE: rtl/core/ahic_queue.sv
// ----------------------------------------------------------------------------
// ahic_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ahic_queue import ahic_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   input  wire ahic_item_type push_item,
   output ahic_qstat_type     q_stat,
   output logic               pop_valid,
   output ahic_item_type      pop_item,
   input  wire logic          pop
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

   ahic_item_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign q_stat.full = (count_ff == DEPTH_C);
   assign pop_valid   = (count_ff != '0);
   assign pop_item    = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && !q_stat.full;
   assign do_pop  = pop && pop_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/ahic_back.sv
// ----------------------------------------------------------------------------
// ahic_back
// Updates the counters and snapshots, forms and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ahic_back import ahic_pkg::*; #(
   parameter int unsigned MAX_LEN = MAX_LEN_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  wire ahic_item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [OUT_W-1:0]   rsp_hamming_distance,
   output logic [OUT_W-1:0]   rsp_indel_count,
   output logic [OUT_W-1:0]   rsp_substitution_count,
   output logic               rsp_length_overflow
);

   localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
   localparam int unsigned EXT_W = (CNT_W > OUT_W) ? CNT_W : OUT_W;
   localparam logic [CNT_W-1:0] LEN_LIMIT = CNT_W'(MAX_LEN);

   // Clamp a count to the result width
   function automatic logic [OUT_W-1:0] sat_out(input logic [CNT_W-1:0] v);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(v);
      if (ext > EXT_W'(OUT_MAX)) begin
         return OUT_W'(OUT_MAX);
      end
      return ext[OUT_W-1:0];
   endfunction

   // The running mismatch count always equals the full count, so one
   // register serves both.
   logic [CNT_W-1:0] pos_ff,    pos_in,    pos_upd;
   logic [CNT_W-1:0] mism_ff,   mism_in,   mism_upd;
   logic [CNT_W-1:0] indel_ff,  indel_in,  indel_upd;
   logic [CNT_W-1:0] end_a_ff,  end_a_in,  end_a_upd;
   logic [CNT_W-1:0] smm_a_ff,  smm_a_in,  smm_a_upd;
   logic [CNT_W-1:0] sind_a_ff, sind_a_in, sind_a_upd;
   logic [CNT_W-1:0] end_b_ff,  end_b_in,  end_b_upd;
   logic [CNT_W-1:0] smm_b_ff,  smm_b_in,  smm_b_upd;
   logic [CNT_W-1:0] sind_b_ff, sind_b_in, sind_b_upd;
   logic             ovf_ff,    ovf_in,    ovf_upd;

   logic             in_range;
   logic [CNT_W-1:0] pos_inc;
   logic [CNT_W-1:0] trim_mm;
   logic [CNT_W-1:0] trim_ind;
   logic [CNT_W-1:0] eff;
   logic [CNT_W-1:0] subs;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] ham_ff,  ham_in;
   logic [OUT_W-1:0] ind_ff,  ind_in;
   logic [OUT_W-1:0] sub_ff,  sub_in;
   logic             lovf_ff, lovf_in;

   // Take an item unless it ends a sequence while the result slot is blocked
   assign q_pop = q_valid && (!q_item.last || !rsp_valid_ff || !rsp_stall);

   // Apply one position to the counters
   always_comb begin
      in_range   = (pos_ff < LEN_LIMIT);
      pos_inc    = pos_ff + 1'b1;
      pos_upd    = pos_ff;
      mism_upd   = mism_ff;
      indel_upd  = indel_ff;
      end_a_upd  = end_a_ff;
      smm_a_upd  = smm_a_ff;
      sind_a_upd = sind_a_ff;
      end_b_upd  = end_b_ff;
      smm_b_upd  = smm_b_ff;
      sind_b_upd = sind_b_ff;
      ovf_upd    = ovf_ff;
      if (in_range) begin
         pos_upd = pos_inc;
         if (q_item.diff) begin
            mism_upd = mism_ff + 1'b1;
            if (q_item.a_gap || q_item.b_gap) begin
               indel_upd = indel_ff + 1'b1;
            end
         end
         if (!q_item.a_gap) begin
            end_a_upd  = pos_inc;
            smm_a_upd  = mism_upd;
            sind_a_upd = indel_upd;
         end
         if (!q_item.b_gap) begin
            end_b_upd  = pos_inc;
            smm_b_upd  = mism_upd;
            sind_b_upd = indel_upd;
         end
      end else begin
         ovf_upd = 1'b1;
      end
   end

   // Pick the shorter prefix and form the counts
   always_comb begin
      if (end_a_upd <= end_b_upd) begin
         trim_mm  = smm_a_upd;
         trim_ind = sind_a_upd;
      end else begin
         trim_mm  = smm_b_upd;
         trim_ind = sind_b_upd;
      end
      eff  = (trim_ind != '0) ? trim_mm : mism_upd;
      subs = (eff >= trim_ind) ? (eff - trim_ind) : '0;
   end

   // Commit the update, clear after the last position
   always_comb begin
      pos_in    = pos_ff;
      mism_in   = mism_ff;
      indel_in  = indel_ff;
      end_a_in  = end_a_ff;
      smm_a_in  = smm_a_ff;
      sind_a_in = sind_a_ff;
      end_b_in  = end_b_ff;
      smm_b_in  = smm_b_ff;
      sind_b_in = sind_b_ff;
      ovf_in    = ovf_ff;
      if (q_pop) begin
         if (q_item.last) begin
            pos_in    = '0;
            mism_in   = '0;
            indel_in  = '0;
            end_a_in  = '0;
            smm_a_in  = '0;
            sind_a_in = '0;
            end_b_in  = '0;
            smm_b_in  = '0;
            sind_b_in = '0;
            ovf_in    = 1'b0;
         end else begin
            pos_in    = pos_upd;
            mism_in   = mism_upd;
            indel_in  = indel_upd;
            end_a_in  = end_a_upd;
            smm_a_in  = smm_a_upd;
            sind_a_in = sind_a_upd;
            end_b_in  = end_b_upd;
            smm_b_in  = smm_b_upd;
            sind_b_in = sind_b_upd;
            ovf_in    = ovf_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         mism_ff   <= '0;
         indel_ff  <= '0;
         end_a_ff  <= '0;
         smm_a_ff  <= '0;
         sind_a_ff <= '0;
         end_b_ff  <= '0;
         smm_b_ff  <= '0;
         sind_b_ff <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         mism_ff   <= mism_in;
         indel_ff  <= indel_in;
         end_a_ff  <= end_a_in;
         smm_a_ff  <= smm_a_in;
         sind_a_ff <= sind_a_in;
         end_b_ff  <= end_b_in;
         smm_b_ff  <= smm_b_in;
         sind_b_ff <= sind_b_in;
         ovf_ff    <= ovf_in;
      end
   end

   // Load the result register, drop it once transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      ham_in       = ham_ff;
      ind_in       = ind_ff;
      sub_in       = sub_ff;
      lovf_in      = lovf_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (q_pop && q_item.last) begin
         rsp_valid_in = 1'b1;
         ham_in       = sat_out(mism_upd);
         ind_in       = sat_out(trim_ind);
         sub_in       = sat_out(subs);
         lovf_in      = ovf_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ham_ff  <= ham_in;
      ind_ff  <= ind_in;
      sub_ff  <= sub_in;
      lovf_ff <= lovf_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_hamming_distance   = ham_ff;
   assign rsp_indel_count        = ind_ff;
   assign rsp_substitution_count = sub_ff;
   assign rsp_length_overflow    = lovf_ff;

`ifndef SYNTH
   a_count_order: assert property (@(posedge clock) disable iff (reset)
      (indel_ff <= mism_ff) && (mism_ff <= pos_ff) && (pos_ff <= LEN_LIMIT))
      else $error("counter ordering broken");

   a_snap_bound: assert property (@(posedge clock) disable iff (reset)
      (end_a_ff <= pos_ff) && (end_b_ff <= pos_ff) &&
      (sind_a_ff <= smm_a_ff) && (sind_b_ff <= smm_b_ff))
      else $error("snapshot beyond running counts");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_item.last) |=> (pos_ff == '0) && (mism_ff == '0) && rsp_valid_ff)
      else $error("sequence end did not clear state or post a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(q_pop && q_item.last))
      else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/aligned_hamming_indel_counter.sv
// ----------------------------------------------------------------------------
// aligned_hamming_indel_counter
// Hamming distance and indel count over two aligned byte sequences.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one aligned position pair per transfer, with
//   req_last_position high on the final pair. A transfer takes place when
//   req_valid is high and req_stall is low. After the final pair the rsp_
//   channel posts one result: full Hamming distance, indels in the trimmed
//   region, substitutions and a length overflow flag.
//   The csr_ channel writes the gap code; csr_ready is always high.
//   Throughput is one pair per cycle while req_stall stays low. The final
//   pair is written into the queue when it transfers, and the back end
//   loads the result register when it pops that pair, so the result
//   reaches rsp_ through the queue and the result register.
//   While rsp_stall holds a result, pairs that do not end a sequence keep
//   flowing; a final pair waits in the queue, and req_stall rises once the
//   two-entry queue fills.
//   Synchronous active-high reset clears the counters, the queue and the
//   result valid flag and restores the gap code to ASCII dash.
// ----------------------------------------------------------------------------
`default_nettype none

module aligned_hamming_indel_counter import ahic_pkg::*; #(
   parameter int unsigned MAX_LEN = MAX_LEN_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [CHAR_W-1:0] req_char_a,
   input  wire logic [CHAR_W-1:0] req_char_b,
   input  wire logic              req_last_position,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [OUT_W-1:0]       rsp_hamming_distance,
   output logic [OUT_W-1:0]       rsp_indel_count,
   output logic [OUT_W-1:0]       rsp_substitution_count,
   output logic                   rsp_length_overflow,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CHAR_W-1:0] csr_data
);

   ahic_qstat_type q_stat;
   logic           push_valid;
   ahic_item_type  push_item;
   logic           pop_valid;
   ahic_item_type  pop_item;
   logic           pop;

   // Accept and classify
   ahic_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_a        (req_char_a),
      .req_char_b        (req_char_b),
      .req_last_position (req_last_position),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .q_stat            (q_stat),
      .push_valid        (push_valid),
      .push_item         (push_item)
   );

   // Decouple front and back
   ahic_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .q_stat     (q_stat),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop)
   );

   // Count and report
   ahic_back #(
      .MAX_LEN (MAX_LEN)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .q_valid                (pop_valid),
      .q_item                 (pop_item),
      .q_pop                  (pop),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_hamming_distance   (rsp_hamming_distance),
      .rsp_indel_count        (rsp_indel_count),
      .rsp_substitution_count (rsp_substitution_count),
      .rsp_length_overflow    (rsp_length_overflow)
   );

endmodule

`default_nettype wire

FILE: sim/aligned_hamming_indel_counter_tb.sv
// ----------------------------------------------------------------------------
// aligned_hamming_indel_counter_tb
// Self-checking bench for the aligned Hamming distance and indel counter.
// Position pairs stream in with bursty valid. The result side stalls on its
// own pattern and once for a long stretch. A scoreboard recomputes every
// result from the accepted pairs and compares each result field. Phases run
// under several gap codes, including both byte extremes.
// ----------------------------------------------------------------------------
module aligned_hamming_indel_counter_tb;
   import ahic_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_POSITIONS = MAX_LEN_DEFAULT;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          DRAIN_CYCLES  = 8;
   localparam int          LONG_HOLD     = 120;

   typedef struct {
      logic [OUT_W-1:0] hamming;
      logic [OUT_W-1:0] indels;
      logic [OUT_W-1:0] substitutions;
      logic             overflow;
   } distance_result_type;

   // Tracks the counters of the current sequence and the results still owed
   class distance_scoreboard;
      logic [CHAR_W-1:0]   gap_code;
      int unsigned         pos_count, full_mm, run_mm, run_ind;
      int unsigned         end_a, mm_a, ind_a, end_b, mm_b, ind_b;
      bit                  overflow;
      distance_result_type pending[$];
      int unsigned         mismatches;

      function new();
         gap_code   = GAP_RESET;
         mismatches = 0;
         clear_sequence();
      endfunction

      function void clear_sequence();
         pos_count = 0; full_mm = 0; run_mm = 0; run_ind = 0;
         end_a = 0; mm_a = 0; ind_a = 0;
         end_b = 0; mm_b = 0; ind_b = 0;
         overflow = 0;
      endfunction

      function void set_gap(logic [CHAR_W-1:0] g);
         gap_code = g;
      endfunction

      function logic [OUT_W-1:0] clip(int unsigned v);
         return (v > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(v);
      endfunction

      // Advance the counters by one accepted pair; queue a result on the last
      function void note_position(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b,
                                  logic last);
         bit                  a_gap, b_gap;
         int unsigned         trim_mm, trim_ind, eff;
         distance_result_type want;
         if (pos_count < MAX_POSITIONS) begin
            a_gap = (a == gap_code);
            b_gap = (b == gap_code);
            if (a != b) begin
               full_mm++;
               run_mm++;
               if (a_gap || b_gap) run_ind++;
            end
            pos_count++;
            if (!a_gap) begin
               end_a = pos_count; mm_a = run_mm; ind_a = run_ind;
            end
            if (!b_gap) begin
               end_b = pos_count; mm_b = run_mm; ind_b = run_ind;
            end
         end else begin
            overflow = 1;
         end
         if (!last) return;
         // Trimmed region ends at the shorter gap-stripped prefix
         if (end_a <= end_b) begin
            trim_mm = mm_a; trim_ind = ind_a;
         end else begin
            trim_mm = mm_b; trim_ind = ind_b;
         end
         eff                = (trim_ind > 0) ? trim_mm : full_mm;
         want.hamming       = clip(full_mm);
         want.indels        = clip(trim_ind);
         want.substitutions = clip((eff >= trim_ind) ? eff - trim_ind : 0);
         want.overflow      = overflow;
         pending.insert(pending.size(), want);
         clear_sequence();
      endfunction

      // Compare a result transfer against the oldest owed result
      function void check_result(distance_result_type got);
         distance_result_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result ham=%0d ind=%0d sub=%0d ovf=%0b",
                        got.hamming, got.indels, got.substitutions, got.overflow);
            return;
         end
         want = pending.pop_front();
         if (got.hamming !== want.hamming || got.indels !== want.indels ||
             got.substitutions !== want.substitutions ||
             got.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: result mismatch expected ham=%0d ind=%0d sub=%0d ",
                         "ovf=%0b, actual ham=%0d ind=%0d sub=%0d ovf=%0b"},
                        want.hamming, want.indels, want.substitutions, want.overflow,
                        got.hamming, got.indels, got.substitutions, got.overflow);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset             = 1'b1;
   logic              req_valid         = 1'b0;
   logic              req_stall;
   logic [CHAR_W-1:0] req_char_a        = '0;
   logic [CHAR_W-1:0] req_char_b        = '0;
   logic              req_last_position = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall         = 1'b0;
   logic [OUT_W-1:0]  rsp_hamming_distance;
   logic [OUT_W-1:0]  rsp_indel_count;
   logic [OUT_W-1:0]  rsp_substitution_count;
   logic              rsp_length_overflow;
   logic              csr_valid         = 1'b0;
   logic              csr_ready;
   logic [CHAR_W-1:0] csr_data          = '0;

   distance_scoreboard board;
   int                 cycle_count    = 0;
   int                 positions_sent = 0;
   int                 burst_left     = 0;
   bit                 bursty         = 1'b1;
   int                 hold_requests  = 0;
   int                 holds_served   = 0;
   int                 hold_left      = 0;
   int                 stall_cycle    = 0;

   aligned_hamming_indel_counter #(
      .MAX_LEN(MAX_POSITIONS)
   ) dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_char_a             (req_char_a),
      .req_char_b             (req_char_b),
      .req_last_position      (req_last_position),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_hamming_distance   (rsp_hamming_distance),
      .rsp_indel_count        (rsp_indel_count),
      .rsp_substitution_count (rsp_substitution_count),
      .rsp_length_overflow    (rsp_length_overflow),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_data               (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Count cycles, end a hung run, check each result transfer
   always @(posedge clock) begin
      distance_result_type got;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         got.hamming       = rsp_hamming_distance;
         got.indels        = rsp_indel_count;
         got.substitutions = rsp_substitution_count;
         got.overflow      = rsp_length_overflow;
         board.check_result(got);
      end
   end

   // Result-side stall: a long hold on request, otherwise a rotating pattern
   always @(negedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_requests != holds_served) begin
         holds_served <= holds_served + 1;
         hold_left    <= LONG_HOLD;
         rsp_stall    <= 1'b1;
      end else begin
         case ((stall_cycle / 250) % 4)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 99) < 30);
            2:       rsp_stall <= ((stall_cycle % 5) < 2);
            default: rsp_stall <= ($urandom_range(0, 99) < 70);
         endcase
      end
   end

   // Offer one pair, with a random gap between bursts; hold until it transfers
   task automatic send_position(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b,
                                logic last);
      int pause;
      if (bursty && burst_left == 0) begin
         pause = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (pause - 1) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_valid         <= 1'b1;
      req_char_a        <= a;
      req_char_b        <= b;
      req_last_position <= last;
      do @(posedge clock); while (req_stall);
      board.note_position(a, b, last);
      positions_sent++;
   endtask

   // Drop valid and wait until every owed result has come out
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_gap(logic [CHAR_W-1:0] g);
      drain_block();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= g;
      do @(posedge clock); while (!csr_ready);
      board.set_gap(g);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Gap, nucleotide or any byte
   function automatic logic [CHAR_W-1:0] pick_symbol(int gap_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < gap_pct) return board.gap_code;
      if (r < gap_pct + 70) begin
         case ($urandom_range(0, 3))
            0:       return "A";
            1:       return "C";
            2:       return "G";
            default: return "T";
         endcase
      end
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   // One sequence with random content and optional trailing gap runs
   task automatic send_sequence(int len, int gap_pct, int mut_pct, int tail_a,
                                int tail_b);
      logic [CHAR_W-1:0] a, b;
      for (int i = 0; i < len; i++) begin
         a = pick_symbol(gap_pct);
         b = ($urandom_range(0, 99) < mut_pct) ? pick_symbol(gap_pct) : a;
         if (i >= len - tail_a) a = board.gap_code;
         if (i >= len - tail_b) b = board.gap_code;
         send_position(a, b, i == len - 1);
      end
   endtask

   task automatic run_random_phase(int count);
      int start, kind, len, tail_a, tail_b;
      start = positions_sent;
      while (positions_sent - start < count) begin
         kind   = $urandom_range(0, 9);
         len    = (kind == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
         tail_a = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len) : 0;
         tail_b = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len) : 0;
         // Noise: dense gaps and unrelated bytes
         if (kind == 9) send_sequence(len, 50, 100, 0, 0);
         else send_sequence(len, $urandom_range(0, 30), $urandom_range(0, 60),
                            tail_a, tail_b);
      end
   endtask

   initial begin
      board = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Identical single position, then a plain substitution
      send_position("A", "A", 1'b1);
      send_position("A", "A", 1'b0);
      send_position("C", "G", 1'b1);
      // Trailing gap in the first sequence trims the region
      send_position("A", "A", 1'b0);
      send_position("C", "C", 1'b0);
      send_position("G", "G", 1'b0);
      send_position("-", "T", 1'b1);
      // Inner indel plus a substitution, equal prefixes
      send_position("A", "A", 1'b0);
      send_position("-", "G", 1'b0);
      send_position("C", "C", 1'b0);
      send_position("T", "A", 1'b1);
      // All gaps on both sides
      send_position("-", "-", 1'b0);
      send_position("-", "-", 1'b1);
      // Empty first prefix against one base
      send_position("-", "X", 1'b1);
      // Byte extremes
      send_position(8'h00, 8'hFF, 1'b0);
      send_position(8'hFF, 8'h00, 1'b0);
      send_position(8'hFF, 8'hFF, 1'b1);
      // Shorter second prefix with an indel inside it
      send_position("G", "-", 1'b0);
      send_position("A", "A", 1'b0);
      send_position("T", "-", 1'b1);

      // Too many positions: every counted pair differs, one extra overflows
      for (int i = 0; i <= MAX_POSITIONS; i++)
         send_position("A", "C", i == MAX_POSITIONS);

      run_random_phase(110);

      // Long result hold while short sequences keep coming
      drain_block();
      hold_requests++;
      bursty = 1'b0;
      repeat (40) send_sequence($urandom_range(1, 2), 20, 50, 0, 0);
      bursty = 1'b1;

      write_gap(8'h00);
      bursty = 1'b0;
      run_random_phase(110);
      bursty = 1'b1;
      write_gap(8'hFF);
      run_random_phase(110);
      write_gap(CHAR_W'($urandom_range(0, 255)));
      run_random_phase(110);
      write_gap(GAP_RESET);
      run_random_phase(60);
      drain_block();

      if (board.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
